// File: hdl/lba_pkg.sv
package lba_pkg;

  localparam int CMD_W      = 1;
  localparam int LIFETIME_W = 32;
  localparam int ELAPSED_W  = 31;
  localparam int BINDEX_W   = 17;
  localparam int FELEM_W    = 25;
  localparam int RCOUNT_W   = 7;

  localparam int MAXB_W     = 7;
  localparam int BBASE_W    = 16;
  localparam int EBASE_W    = 24;
  localparam int BLEN_W     = 16;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CMD_W-1:0] CMD_SPAWN = 1'b0;
  localparam logic [CMD_W-1:0] CMD_TICK  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_BLOCKS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BASE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_BASE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH = 2'd3;

  localparam logic [MAXB_W-1:0]  MAX_BLOCKS_RST   = 7'd64;
  localparam logic [BLEN_W-1:0]  BLOCK_LENGTH_RST = 16'd64;

endpackage

// File: hdl/lifetime_block_allocator.sv
// channel | beat                                        | flow control
// --------+---------------------------------------------+------------------------
// in      | command, lifetime, elapsed                  | in_valid / in_stall
// out     | granted, block_index, first_element,        | out_valid / out_stall
//         | released_count, empty_res                   |
// cfg     | cfg_write, cfg_index, cfg_data              | none, write-only
//
// One command at a time. Refused spawn: S_FINISH; fresh block: S_GRANT, S_FINISH;
// reused block: S_POP (free stack read), S_GRANT, S_FINISH. Tick: S_TICK walks the
// blocks ever used, one lifetime memory read-modify-write per cycle; none in use: S_FINISH.
// Reset clears counters and control; both memories start undefined, no clearing pass.
// A finished beat waits in the output register under out_stall; the next command is
// still taken, and its result waits until the register empties.
module lifetime_block_allocator #(
  parameter int MAX_BLOCKS = 64,
  parameter int LIFE_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [lba_pkg::CMD_W-1:0]        command,
  input  logic signed [lba_pkg::LIFETIME_W-1:0] lifetime,
  input  logic [lba_pkg::ELAPSED_W-1:0]    elapsed,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             granted,
  output logic [lba_pkg::BINDEX_W-1:0]     block_index,
  output logic [lba_pkg::FELEM_W-1:0]      first_element,
  output logic [lba_pkg::RCOUNT_W-1:0]     released_count,
  output logic                             empty_res,
  input  logic                             cfg_write,
  input  logic [lba_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lba_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import lba_pkg::*;

  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int CW    = (CNT_W > MAXB_W) ? CNT_W : MAXB_W;
  localparam int SW    = ((LIFE_WIDTH > ELAPSED_W) ? LIFE_WIDTH : ELAPSED_W) + 2;
  localparam int PW    = IDX_W + BLEN_W;
  localparam int SUMW  = ((PW > EBASE_W) ? PW : EBASE_W) + 1;

  localparam logic signed [SW-1:0] LIFE_MAX =
    $signed({{(SW-LIFE_WIDTH+1){1'b0}}, {(LIFE_WIDTH-1){1'b1}}});
  localparam logic signed [SW-1:0] LIFE_MIN = ~LIFE_MAX;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_GRANT,
    S_TICK,
    S_FINISH
  } state_t;

  state_t state;

  logic [MAXB_W-1:0]  max_blocks;
  logic [BBASE_W-1:0] block_base;
  logic [EBASE_W-1:0] element_base;
  logic [BLEN_W-1:0]  block_length;

  logic [CNT_W-1:0]      free_count;
  logic [CNT_W-1:0]      high_water;
  logic [CNT_W-1:0]      released;
  logic [IDX_W-1:0]      walk_idx;
  logic [IDX_W-1:0]      local_blk;
  logic [LIFE_WIDTH-1:0] life_sat;
  logic [ELAPSED_W-1:0]  elapsed_r;
  logic [PW-1:0]         prod;
  logic                  ok;

  logic                  accept;
  logic                  fresh_ok;
  logic                  out_free;
  logic [CNT_W-1:0]      walk_next;
  logic signed [SW-1:0]  spawn_ext;
  logic signed [SW-1:0]  spawn_sat;
  logic signed [SW-1:0]  life_ext;
  logic signed [SW-1:0]  elapsed_ext;
  logic signed [SW-1:0]  dec;
  logic signed [SW-1:0]  dec_sat;
  logic                  expire;
  logic                  push;

  logic                  life_we;
  logic [IDX_W-1:0]      life_waddr;
  logic [LIFE_WIDTH-1:0] life_wdata;
  logic [IDX_W-1:0]      life_raddr;
  logic [LIFE_WIDTH-1:0] life_rdata;
  logic [IDX_W-1:0]      stack_waddr;
  logic [IDX_W-1:0]      stack_raddr;
  logic [IDX_W-1:0]      stack_rdata;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign fresh_ok = (CW'(high_water) < CW'(max_blocks)) && (high_water < CNT_MAX);
  assign walk_next = CNT_W'(walk_idx) + CNT_W'(1);

  always_comb begin
    spawn_ext = SW'(lifetime);
    if (spawn_ext > LIFE_MAX) begin
      spawn_sat = LIFE_MAX;
    end else if (spawn_ext < LIFE_MIN) begin
      spawn_sat = LIFE_MIN;
    end else begin
      spawn_sat = spawn_ext;
    end
  end

  always_comb begin
    life_ext    = SW'($signed(life_rdata));
    elapsed_ext = $signed(SW'(elapsed_r));
    dec         = life_ext - elapsed_ext;
    dec_sat     = (dec < LIFE_MIN) ? LIFE_MIN : dec;
    expire      = dec_sat[SW-1];
  end

  assign push = (state == S_TICK) && !life_ext[SW-1] && expire && (free_count < CNT_MAX);

  always_comb begin
    life_we    = 1'b0;
    life_waddr = walk_idx;
    life_wdata = dec_sat[LIFE_WIDTH-1:0];
    if (state == S_GRANT) begin
      life_we    = 1'b1;
      life_waddr = local_blk;
      life_wdata = life_sat;
    end else if (state == S_TICK) begin
      life_we = !life_ext[SW-1];
    end
  end

  assign life_raddr  = (state == S_TICK) ? walk_next[IDX_W-1:0] : '0;
  assign stack_waddr = free_count[IDX_W-1:0];
  assign stack_raddr = IDX_W'(free_count - CNT_W'(1));

  lba_ram #(
    .WIDTH (LIFE_WIDTH),
    .DEPTH (MAX_BLOCKS)
  ) u_life_ram (
    .clk     (clk),
    .wr_en   (life_we),
    .wr_addr (life_waddr),
    .wr_data (life_wdata),
    .rd_addr (life_raddr),
    .rd_data (life_rdata)
  );

  lba_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_BLOCKS)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (push),
    .wr_addr (stack_waddr),
    .wr_data (walk_idx),
    .rd_addr (stack_raddr),
    .rd_data (stack_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_blocks   <= MAX_BLOCKS_RST;
      block_base   <= '0;
      element_base <= '0;
      block_length <= BLOCK_LENGTH_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MAX_BLOCKS:   max_blocks   <= cfg_data[MAXB_W-1:0];
        REG_BLOCK_BASE:   block_base   <= cfg_data[BBASE_W-1:0];
        REG_ELEMENT_BASE: element_base <= cfg_data[EBASE_W-1:0];
        REG_BLOCK_LENGTH: block_length <= cfg_data[BLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      free_count <= '0;
      high_water <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            ok       <= 1'b0;
            released <= '0;
            if (command == CMD_TICK) begin
              elapsed_r <= elapsed;
              walk_idx  <= '0;
              // read of entry 0 issued this cycle
              state     <= (free_count == high_water) ? S_FINISH : S_TICK;
            end else begin
              life_sat <= spawn_sat[LIFE_WIDTH-1:0];
              if (free_count != '0) begin
                free_count <= free_count - CNT_W'(1);
                state      <= S_POP;
              end else if (fresh_ok) begin
                local_blk  <= high_water[IDX_W-1:0];
                high_water <= high_water + CNT_W'(1);
                state      <= S_GRANT;
              end else begin
                state <= S_FINISH;
              end
            end
          end
        end
        S_POP: begin
          local_blk <= stack_rdata;
          state     <= S_GRANT;
        end
        S_GRANT: begin
          ok    <= 1'b1;
          prod  <= PW'(local_blk) * PW'(block_length);
          state <= S_FINISH;
        end
        S_TICK: begin
          if (push) begin
            free_count <= free_count + CNT_W'(1);
            released   <= released + CNT_W'(1);
          end
          walk_idx <= walk_next[IDX_W-1:0];
          if (walk_next == high_water) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            granted        <= ok;
            block_index    <= ok ? BINDEX_W'(BINDEX_W'(block_base) + BINDEX_W'(local_blk))
                                 : '0;
            first_element  <= ok ? FELEM_W'(SUMW'(element_base) + SUMW'(prod)) : '0;
            released_count <= RCOUNT_W'(released);
            empty_res      <= (free_count == high_water);
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/lba_ram.sv
module lba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
